/* hdl/tagt_pkg.sv */
// shared types and constants of the aging guard table
`default_nettype none
package tagt_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned InDataW    = 128;
  localparam int unsigned InUserW    = 4;
  localparam int unsigned OutDataW   = 88;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_LIST   = 2'd3
  } tagt_op_e;

  typedef enum logic [1:0] {
    KIND_DYNAMIC = 2'd0,
    KIND_STATIC  = 2'd1,
    KIND_BAD2    = 2'd2,
    KIND_BAD3    = 2'd3
  } tagt_kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_INVALID   = 2'd3
  } tagt_status_e;

  localparam logic [CfgIdxW-1:0] CFG_MAX_ENTRIES    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TTL_SECONDS    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHECK_INTERVAL = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic         load;
    logic         stamp;
    logic         scan;
    logic         emit;
    tagt_status_e status;
  } tagt_cmd_t;

  // datapath to controller
  typedef struct packed {
    tagt_op_e   op;
    tagt_kind_e kind;
    logic       full;
    logic       early;
    logic       done;
    logic       found;
    logic       emitted;
    logic       out_free;
  } tagt_stat_t;

endpackage
`default_nettype wire

/* hdl/tagt_ctrl.sv */
// controller state machine of the aging guard table
`default_nettype none
module tagt_ctrl import tagt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire tagt_stat_t stat_i,
  output tagt_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e       state_q, state_d;
  tagt_status_e status_q, status_d;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat_i.op)
          OP_ADD: begin
            if (stat_i.kind == KIND_STATIC) begin
              status_d = ST_OK;
              state_d  = S_EMIT;
            end else if (stat_i.kind != KIND_DYNAMIC) begin
              status_d = ST_INVALID;
              state_d  = S_EMIT;
            end else if (stat_i.full) begin
              status_d = ST_FULL;
              state_d  = S_EMIT;
            end else begin
              state_d = S_SCAN;
            end
          end
          OP_TICK: begin
            if (stat_i.early) begin
              status_d = ST_OK;
              state_d  = S_EMIT;
            end else begin
              state_d = S_SCAN;
            end
          end
          default: state_d = S_SCAN;
        endcase
      end
      S_SCAN: begin
        if (stat_i.done) begin
          state_d = S_EMIT;
          unique case (stat_i.op)
            OP_ADD:    status_d = stat_i.found ? ST_OK : ST_FULL;
            OP_REMOVE: status_d = stat_i.found ? ST_OK : ST_NOT_FOUND;
            OP_TICK:   status_d = ST_OK;
            default: begin
              status_d = ST_NOT_FOUND;
              // listed entries already carried the closing result
              if (stat_i.emitted) state_d = S_IDLE;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.stamp   = (state_q == S_DISPATCH) && (stat_i.op == OP_TICK) && !stat_i.early;
  assign cmd_o.scan    = (state_q == S_SCAN);
  assign cmd_o.emit    = (state_q == S_EMIT) && stat_i.out_free;
  assign cmd_o.status  = status_q;

endmodule
`default_nettype wire

/* hdl/tagt_dp.sv */
// datapath of the aging guard table: entry memory, valid bits, scan and result register
`default_nettype none
module tagt_dp import tagt_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tagt_cmd_t           cmd_i,
  output tagt_stat_t               stat_o,
  input  wire logic [InDataW-1:0]  in_data_i,
  input  wire logic [InUserW-1:0]  in_user_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OutDataW-1:0]      out_data_o,
  output logic [1:0]               out_user_o,
  output logic                     out_last_o
);

  typedef struct packed {
    logic [31:0] addr;
    logic [47:0] mac;
    logic [11:0] vlan;
    logic [31:0] created;
    logic [31:0] ttl;
  } entry_t;

  localparam logic [CntW-1:0] DepthCnt = CntW'(TableDepth);

  // configuration
  logic [6:0]  max_entries_q;
  logic [31:0] ttl_seconds_q;
  logic [15:0] check_interval_q;

  // table state
  entry_t                  mem [TableDepth];
  logic [TableDepth-1:0]   valid_q;
  logic [CntW-1:0]         count_q;
  logic [31:0]             last_sweep_q;

  // current request
  tagt_op_e    op_q;
  tagt_kind_e  kind_q;
  logic [31:0] ip_q;
  logic [47:0] mac_q;
  logic [11:0] vlan_q;
  logic [31:0] now_q;

  // scan
  logic [CntW-1:0] idx_q;
  logic [IdxW-1:0] eidx_q;
  logic            ev_vld_q;
  entry_t          rd_q;
  logic            found_q;
  logic            emitted_q;
  logic [IdxW-1:0] slot_q;
  logic [CntW-1:0] expired_q;

  // result register
  logic            out_vld_q;
  tagt_status_e    res_status_q;
  logic [CntW-1:0] res_count_q;
  logic [CntW-1:0] res_expired_q;
  logic [IdxW-1:0] res_slot_q;
  logic [31:0]     res_ip_q;
  logic [31:0]     res_ttl_q;
  logic            res_last_q;

  logic [IdxW-1:0] idx6;
  logic            out_free, done, act, is_add, slot_free, issue, ev_entry_valid;
  logic            stall, list_load, rm_hit, tick_hit, any_above, full, early;
  logic [CntW-1:0] limit;
  logic [31:0]     since, elapsed, ttl_rem;
  logic [32:0]     ends, remain;

  assign idx6      = idx_q[IdxW-1:0];
  assign out_free  = !out_vld_q || out_ready_i;
  assign is_add    = (op_q == OP_ADD);
  assign done      = is_add ? (found_q || idx_q == DepthCnt)
                            : (found_q || (idx_q == DepthCnt && !ev_vld_q));
  assign act       = cmd_i.scan && !done;
  assign slot_free = !valid_q[idx6];

  assign ev_entry_valid = ev_vld_q && valid_q[eidx_q];
  assign rm_hit   = (op_q == OP_REMOVE) && ev_entry_valid && (rd_q.addr == ip_q);
  // creation plus lifetime taken at 33 bits so it never wraps
  assign ends     = {1'b0, rd_q.created} + {1'b0, rd_q.ttl};
  assign tick_hit = (op_q == OP_TICK) && ev_entry_valid && (rd_q.ttl != 32'd0)
                    && (ends < {1'b0, now_q});
  assign stall     = (op_q == OP_LIST) && ev_entry_valid && !out_free;
  assign list_load = act && (op_q == OP_LIST) && ev_entry_valid && out_free;
  assign issue     = act && !is_add && !stall && (idx_q != DepthCnt) && !found_q;
  assign any_above = |((valid_q >> eidx_q) >> 1);

  assign elapsed  = (now_q > rd_q.created) ? (now_q - rd_q.created) : 32'd0;
  assign remain   = {1'b0, rd_q.ttl} - {1'b0, elapsed};
  assign ttl_rem  = (rd_q.ttl == 32'd0 || remain[32]) ? 32'd0 : remain[31:0];

  // a limit of zero or above the depth acts as the depth
  assign limit = (max_entries_q == 7'd0 || max_entries_q > 7'(TableDepth))
                 ? DepthCnt : CntW'(max_entries_q);
  assign full  = (count_q >= limit) || (count_q >= DepthCnt);
  assign since = now_q - last_sweep_q;
  assign early = (last_sweep_q != 32'd0) && (since < {16'd0, check_interval_q});

  assign stat_o.op       = op_q;
  assign stat_o.kind     = kind_q;
  assign stat_o.full     = full;
  assign stat_o.early    = early;
  assign stat_o.done     = done;
  assign stat_o.found    = found_q;
  assign stat_o.emitted  = emitted_q;
  assign stat_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q    <= 7'd64;
      ttl_seconds_q    <= 32'd0;
      check_interval_q <= 16'd60;
      valid_q          <= '0;
      count_q          <= '0;
      last_sweep_q     <= 32'd0;
      idx_q            <= '0;
      ev_vld_q         <= 1'b0;
      found_q          <= 1'b0;
      emitted_q        <= 1'b0;
      out_vld_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_ENTRIES:    max_entries_q    <= cfg_data_i[6:0];
          CFG_TTL_SECONDS:    ttl_seconds_q    <= cfg_data_i;
          CFG_CHECK_INTERVAL: check_interval_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        idx_q     <= '0;
        ev_vld_q  <= 1'b0;
        found_q   <= 1'b0;
        emitted_q <= 1'b0;
      end
      if (cmd_i.stamp) last_sweep_q <= now_q;
      if (act) begin
        if (is_add) begin
          if (slot_free) begin
            valid_q[idx6] <= 1'b1;
            count_q       <= count_q + 1'b1;
            found_q       <= 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end else begin
          if (!stall) begin
            ev_vld_q <= issue;
            if (issue) idx_q <= idx_q + 1'b1;
          end
          if (rm_hit || tick_hit) begin
            valid_q[eidx_q] <= 1'b0;
            count_q         <= count_q - 1'b1;
          end
          if (rm_hit) found_q <= 1'b1;
          if (list_load) emitted_q <= 1'b1;
        end
      end
      if (cmd_i.emit || list_load) out_vld_q <= 1'b1;
      else if (out_ready_i)        out_vld_q <= 1'b0;
    end
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (act && is_add && slot_free) begin
      mem[idx6] <= '{addr: ip_q, mac: mac_q, vlan: vlan_q,
                     created: now_q, ttl: ttl_seconds_q};
    end
    if (issue) rd_q <= mem[idx6];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= tagt_op_e'(in_user_i[1:0]);
      kind_q    <= tagt_kind_e'(in_user_i[3:2]);
      ip_q      <= in_data_i[31:0];
      mac_q     <= in_data_i[79:32];
      vlan_q    <= in_data_i[91:80];
      now_q     <= in_data_i[123:92];
      slot_q    <= '0;
      expired_q <= '0;
    end
    if (act && is_add && slot_free) slot_q <= idx6;
    if (issue) eidx_q <= idx6;
    if (act && tick_hit) expired_q <= expired_q + 1'b1;
    if (cmd_i.emit) begin
      res_status_q  <= cmd_i.status;
      res_count_q   <= count_q;
      res_expired_q <= expired_q;
      res_slot_q    <= slot_q;
      res_ip_q      <= 32'd0;
      res_ttl_q     <= 32'd0;
      res_last_q    <= 1'b1;
    end else if (list_load) begin
      res_status_q  <= ST_OK;
      res_count_q   <= count_q;
      res_expired_q <= '0;
      res_slot_q    <= eidx_q;
      res_ip_q      <= rd_q.addr;
      res_ttl_q     <= ttl_rem;
      res_last_q    <= !any_above;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_user_o  = res_status_q;
  assign out_last_o  = res_last_q;
  assign out_data_o  = {4'd0, res_ttl_q, res_ip_q, res_slot_q, res_expired_q, res_count_q};

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'($countones(valid_q)))
    else $error("entry count differs from valid bits");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("entry count above depth");
  a_add_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && is_add && slot_free) |=> valid_q[slot_q])
    else $error("added slot not marked valid");
  a_list_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && stall) |=> (ev_vld_q && $stable(eidx_q)))
    else $error("listed entry lost during output stall");
`endif

endmodule
`default_nettype wire

/* hdl/ttl_aging_guard_table.sv */
// Aging guard table: 64 dynamic entries (address, MAC, VLAN, creation second,
// lifetime) with add, remove, expiry tick and list. One request is worked at a
// time. Add, remove, tick and list walk the table one entry per cycle; an add
// or tick may instead be answered at once. A walk covers at most all 64 slots,
// and a list walk holds while a listed entry waits at the stalled output.
// The next request is taken while the last result still waits.
// No clearing pass follows reset.
`default_nettype none
module ttl_aging_guard_table import tagt_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // ip_key, mac_value, vlan, now_sec, zero pad
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // op, guard_kind
  input  wire logic [InUserW-1:0]  s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // entry_count, expired_count, slot, entry_ip, remaining ttl, zero pad
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // status
  output logic [1:0]               m_axis_tuser_o,
  output logic                     m_axis_tlast_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  tagt_cmd_t  cmd;
  tagt_stat_t stat;

  tagt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tagt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

/* test/ttl_aging_guard_table_tb.sv */
// testbench of the aging guard table: directed and random requests checked against a predictor
`default_nettype none
module ttl_aging_guard_table_tb;
  import tagt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HoldCycles = 400;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainCycles = 100;

  // laid out as the status, then tdata from the top bit down, then last
  typedef struct packed {
    tagt_status_e status;
    logic [31:0]  rem_ttl;
    logic [31:0]  ip;
    logic [5:0]   slot;
    logic [6:0]   expired;
    logic [6:0]   count;
    logic         last;
  } guard_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic [InUserW-1:0]  s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  ttl_aging_guard_table u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of the table and registers
  logic        tbl_valid [TableDepth];
  logic [31:0] tbl_addr [TableDepth];
  logic [31:0] tbl_created [TableDepth];
  logic [31:0] tbl_ttl [TableDepth];
  logic [6:0]  live_count;
  logic [31:0] last_sweep;
  logic [6:0]  lim_cfg;
  logic [31:0] ttl_cfg;
  logic [15:0] interval_cfg;

  guard_result_t pending_results[$];
  int unsigned mismatches, results_seen, requests_sent;
  bit no_idle, hold_req;
  logic [31:0] cur_time;

  function automatic void push_result(tagt_status_e st, logic [6:0] exp_n, logic [5:0] sl,
                                      logic [31:0] ip, logic [31:0] left, logic last);
    guard_result_t r;
    r.status = st; r.count = live_count; r.expired = exp_n; r.slot = sl;
    r.ip = ip; r.rem_ttl = left; r.last = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_request(tagt_op_e op, logic [31:0] ip, tagt_kind_e kind,
                                          logic [31:0] now);
    int free_slot, n;
    logic [6:0] limit, swept;
    logic [32:0] ends;
    logic [31:0] el, left;
    free_slot = -1;
    n = 0;
    swept = '0;
    case (op)
      OP_ADD: begin
        limit = (lim_cfg == 0 || lim_cfg > TableDepth) ? 7'(TableDepth) : lim_cfg;
        if (kind == KIND_STATIC) push_result(ST_OK, 0, 0, 0, 0, 1'b1);
        else if (kind != KIND_DYNAMIC) push_result(ST_INVALID, 0, 0, 0, 0, 1'b1);
        else if (live_count >= limit) push_result(ST_FULL, 0, 0, 0, 0, 1'b1);
        else begin
          for (int i = 0; i < TableDepth; i++)
            if (!tbl_valid[i] && free_slot < 0) free_slot = i;
          if (free_slot < 0) push_result(ST_FULL, 0, 0, 0, 0, 1'b1);
          else begin
            tbl_valid[free_slot] = 1'b1;
            tbl_addr[free_slot] = ip;
            tbl_created[free_slot] = now;
            tbl_ttl[free_slot] = ttl_cfg;
            live_count++;
            push_result(ST_OK, 0, 6'(free_slot), 0, 0, 1'b1);
          end
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < TableDepth; i++)
          if (free_slot < 0 && tbl_valid[i] && tbl_addr[i] == ip) free_slot = i;
        if (free_slot < 0) push_result(ST_NOT_FOUND, 0, 0, 0, 0, 1'b1);
        else begin
          tbl_valid[free_slot] = 1'b0;
          live_count--;
          push_result(ST_OK, 0, 0, 0, 0, 1'b1);
        end
      end
      OP_TICK: begin
        if (last_sweep != 0 && (now - last_sweep) < {16'd0, interval_cfg})
          push_result(ST_OK, 0, 0, 0, 0, 1'b1);
        else begin
          last_sweep = now;
          for (int i = 0; i < TableDepth; i++) begin
            ends = {1'b0, tbl_created[i]} + {1'b0, tbl_ttl[i]};
            if (tbl_valid[i] && tbl_ttl[i] != 0 && ends < {1'b0, now}) begin
              tbl_valid[i] = 1'b0;
              live_count--;
              swept++;
            end
          end
          push_result(ST_OK, swept, 0, 0, 0, 1'b1);
        end
      end
      default: begin
        for (int i = 0; i < TableDepth; i++)
          if (tbl_valid[i]) n++;
        if (n == 0) push_result(ST_NOT_FOUND, 0, 0, 0, 0, 1'b1);
        for (int i = 0; i < TableDepth; i++) begin
          if (tbl_valid[i]) begin
            n--;
            el = (now > tbl_created[i]) ? now - tbl_created[i] : 32'd0;
            left = (tbl_ttl[i] == 0 || el >= tbl_ttl[i]) ? 32'd0 : tbl_ttl[i] - el;
            push_result(ST_OK, 0, 6'(i), tbl_addr[i], left, n == 0);
          end
        end
      end
    endcase
  endfunction

  // called at a rising edge, returns at the rising edge where the request went in
  task automatic send_request(tagt_op_e op, logic [31:0] ip, logic [47:0] mac,
                              logic [11:0] vlan, tagt_kind_e kind, logic [31:0] now);
    s_axis_tdata_i <= {4'd0, now, vlan, mac, ip};
    s_axis_tuser_i <= {kind, op};
    s_axis_tvalid_i <= 1'b1;
    do @(negedge clk_i); while (!s_axis_tready_o);
    predict_request(op, ip, kind, now);
    requests_sent++;
    @(posedge clk_i);
  endtask

  task automatic sender_gap();
    int n;
    n = $urandom_range(1, 19);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_registers(logic [6:0] lim, logic [31:0] ttl, logic [15:0] ivl);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MAX_ENTRIES; cfg_data_i <= {25'd0, lim};
    @(posedge clk_i);
    cfg_idx_i <= CFG_TTL_SECONDS; cfg_data_i <= ttl;
    @(posedge clk_i);
    cfg_idx_i <= CFG_CHECK_INTERVAL; cfg_data_i <= {16'd0, ivl};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lim_cfg = lim; ttl_cfg = ttl; interval_cfg = ivl;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_request(OP_LIST, 0, 0, 0, KIND_DYNAMIC, 32'd0);
    send_request(OP_TICK, 0, 0, 0, KIND_DYNAMIC, 32'd0);   // sweep at zero stays never swept
    send_request(OP_TICK, 0, 0, 0, KIND_DYNAMIC, 32'd5);
    send_request(OP_TICK, 0, 0, 0, KIND_DYNAMIC, 32'd10);  // too early
    send_request(OP_ADD, 32'h1, 48'h1, 12'h1, KIND_STATIC, 32'd1);
    send_request(OP_ADD, 32'h2, 48'h2, 12'h2, KIND_BAD2, 32'd1);
    send_request(OP_ADD, 32'h3, 48'h3, 12'h3, KIND_BAD3, 32'd1);
    send_request(OP_ADD, '1, '1, '1, KIND_DYNAMIC, '1);
    send_request(OP_ADD, 0, 0, 0, KIND_DYNAMIC, 0);
    send_request(OP_REMOVE, 32'h1234_5678, 0, 0, KIND_DYNAMIC, 0);
    send_request(OP_REMOVE, 0, 0, 0, KIND_DYNAMIC, 0);
    wait_idle();
    write_registers(7'd64, '1, 16'd65535);
    send_request(OP_ADD, 32'hA5A5_5A5A, 48'h5A5A_A5A5_0F0F, 12'hA5A, KIND_DYNAMIC, '1);
    send_request(OP_TICK, 0, 0, 0, KIND_DYNAMIC, 32'h7FFF_FFFF);
    // created in the future seen from now
    send_request(OP_LIST, 0, 0, 0, KIND_DYNAMIC, 32'd3);
    wait_idle();
    write_registers(7'd1, 32'd9, 16'd0);
    send_request(OP_ADD, 32'hC0A8_0001, 48'hF00D, 12'h7, KIND_DYNAMIC, 32'd50);
    wait_idle();
    write_registers(7'd127, 32'd9, 16'd0);
    send_request(OP_ADD, 32'hC0A8_0002, 48'hBEEF, 12'h8, KIND_DYNAMIC, 32'd50);
    send_request(OP_LIST, 0, 0, 0, KIND_DYNAMIC, 32'd55);
    wait_idle();
  endtask

  task automatic test_fill_table();
    write_registers(7'd0, 32'd3, 16'd0);
    for (int i = 0; i < 65; i++) begin
      send_request(OP_ADD, $urandom, {$urandom, $urandom}, 12'($urandom), KIND_DYNAMIC,
                   32'd100);
      sender_gap();
    end
    send_request(OP_LIST, 0, 0, 0, KIND_DYNAMIC, 32'd102);
    send_request(OP_TICK, 0, 0, 0, KIND_DYNAMIC, 32'd200);
    send_request(OP_LIST, 0, 0, 0, KIND_DYNAMIC, 32'd200);
    wait_idle();
  endtask

  task automatic random_request();
    int pick, sl;
    logic [31:0] ip;
    pick = $urandom_range(0, 99);
    sl = $urandom_range(0, TableDepth - 1);
    ip = (tbl_valid[sl] && $urandom_range(0, 9) < 7) ? tbl_addr[sl] : $urandom;
    if ($urandom_range(0, 19) == 0) cur_time = $urandom;
    else cur_time = cur_time + $urandom_range(0, 8);
    if (pick < 42)
      send_request(OP_ADD, $urandom, {$urandom, $urandom}, 12'($urandom),
                   ($urandom_range(0, 9) < 8) ? KIND_DYNAMIC : tagt_kind_e'($urandom_range(1, 3)),
                   cur_time);
    else if (pick < 67)
      send_request(OP_REMOVE, ip, 0, 0, tagt_kind_e'($urandom_range(0, 3)), cur_time);
    else if (pick < 87)
      send_request(OP_TICK, $urandom, 0, 0, KIND_DYNAMIC, cur_time);
    else
      send_request(OP_LIST, 0, 0, 0, KIND_DYNAMIC, cur_time);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_registers(7'd64, 32'd10, 16'd0);
        1: write_registers(7'd1, 32'd0, 16'd65535);
        2: write_registers(7'd8, 32'd5, 16'd3);
        3: write_registers(7'd64, '1, 16'd60);
        4: write_registers(7'($urandom_range(1, 64)), $urandom_range(1, 30),
                           16'($urandom_range(0, 10)));
        default: begin
          no_idle = 1'b1;
          write_registers(7'd64, 32'd7, 16'd1);
        end
      endcase
      for (int i = 0; i < 52; i++) begin
        random_request();
        sender_gap();
      end
      wait_idle();
    end
  endtask

  // receiver holds off while the sender keeps offering, then the sender waits for the drain
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) random_request();
    wait_idle();
  endtask

  // receiver: random ready, hold-off on request
  initial begin
    int left, hold;
    bit rdy;
    left = 0;
    rdy = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        for (hold = 0; hold < HoldCycles; hold++) @(posedge clk_i);
        left = 0;
      end
      if (left == 0) begin
        rdy = no_idle || ($urandom_range(0, 2) != 0);
        left = rdy ? $urandom_range(1, 60) : $urandom_range(1, 19);
      end
      left--;
      m_axis_tready_i <= rdy;
    end
  end

  // result checker, sampled mid-cycle ahead of the accepting edge
  initial begin
    guard_result_t act, want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        act = {tagt_status_e'(m_axis_tuser_o), m_axis_tdata_o[83:0], m_axis_tlast_o};
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", act);
        end else begin
          want = pending_results.pop_front();
          if (act != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d cnt=%0d exp=%0d slot=%0d ip=%h ttl=%h last=%b",
                       want.status, want.count, want.expired, want.slot, want.ip,
                       want.rem_ttl, want.last,
                       "\n          act st=%0d cnt=%0d exp=%0d slot=%0d ip=%h ttl=%h last=%b",
                       act.status, act.count, act.expired, act.slot, act.ip,
                       act.rem_ttl, act.last);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet = 0;
      else quiet++;
      if (quiet >= WatchLimit) begin
        $display("ttl_aging_guard_table_tb failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < TableDepth; i++) begin
      tbl_valid[i] = 1'b0; tbl_addr[i] = '0; tbl_created[i] = '0; tbl_ttl[i] = '0;
    end
    live_count = '0; last_sweep = '0;
    lim_cfg = 7'd64; ttl_cfg = '0; interval_cfg = 16'd60;
    mismatches = 0; results_seen = 0; requests_sent = 0;
    no_idle = 1'b0; hold_req = 1'b0; cur_time = 32'd1000;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_table();
    test_backpressure();
    test_random_phases();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered add, remove, tick and list over several limits, lifetimes and intervals");
    $display("%0d requests sent, %0d results checked, %0d mismatches",
             requests_sent, results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("ttl_aging_guard_table_tb passed");
    else
      $display("ttl_aging_guard_table_tb failed");
    $finish;
  end

endmodule
`default_nettype wire
